// ===== design/hsc_pkg.sv =====
`default_nettype none

package hsc_pkg;

  localparam int unsigned KEY_W  = 16;
  localparam int unsigned MARK_W = 10;
  localparam int unsigned TAG_W  = 16;
  localparam int unsigned SWAP_W = 10;

  localparam logic [SWAP_W-1:0] SWAP_MAX = '1;

  // one stored record
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [MARK_W-1:0] marks;
    logic [TAG_W-1:0]  name_tag;
  } rec_t;

endpackage

`default_nettype wire

// ===== design/hsc_in_if.sv =====
`default_nettype none

interface hsc_in_if import hsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key;
  logic [MARK_W-1:0] marks;
  logic [TAG_W-1:0]  name_tag;
  logic              last;

  modport source (output valid, output key, output marks, output name_tag, output last,
                  input ready);
  modport sink   (input valid, input key, input marks, input name_tag, input last,
                  output ready);
endinterface

`default_nettype wire

// ===== design/hsc_out_if.sv =====
`default_nettype none

interface hsc_out_if import hsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  key_res;
  logic [MARK_W-1:0] marks_res;
  logic [TAG_W-1:0]  name_tag_res;
  logic [SWAP_W-1:0] swap_count;
  logic              dropped;
  logic              last_out;

  modport source (output valid, output key_res, output marks_res, output name_tag_res,
                  output swap_count, output dropped, output last_out, input ready);
  modport sink   (input valid, input key_res, input marks_res, input name_tag_res,
                  input swap_count, input dropped, input last_out, output ready);
endinterface

`default_nettype wire

// ===== design/hsc_ram.sv =====
`default_nettype none

module hsc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 42
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/heap_sort_with_swap_count.sv =====
`default_nettype none

// Heap sorter for student records. In the load state, records (key, marks, name
// tag) are taken one per cycle into a record memory of MAX_RECORDS entries;
// records that arrive when the memory is full are discarded and flag "dropped"
// for the set. An item with last set (stored or not) closes the set: the block
// stops taking items, runs an in-place max-heap sort on the key (build by
// sift-down from n/2-1 down to 0, then move the root to the tail and sift down,
// n-1 times), and then emits every record in ascending key order, each result
// carrying the saturating swap count of the sort and the dropped flag; last_out
// marks the final result. The sort is bound by the single read port of the
// record memory: each sift-down level reads the left child, reads the right
// child, then compares and writes back; each build step adds a build and a
// capture state, and each root-to-tail move adds a start, a root capture and a
// tail write. Each result is read, loaded into the output register and held
// until the sink takes it.
module heap_sort_with_swap_count import hsc_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  hsc_in_if.sink     in_i,
  hsc_out_if.source  out_o
);

  localparam int unsigned AW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CW = $clog2(MAX_RECORDS + 1);
  localparam int unsigned XW = AW + 2;   // child index, up to 2*node+2

  typedef enum logic [3:0] {
    S_LOAD,     // taking records
    S_BUILD,    // next heap-build node
    S_TOP,      // capture the record being sifted
    S_LEFT,     // read left child or finish the sift
    S_RIGHT,    // read right child, capture left
    S_CMP,      // pick the largest, write back
    S_EXT,      // start a root-to-tail move
    S_EXT_A,    // capture root, read tail
    S_EXT_B,    // root to tail, tail becomes sifted record
    S_EM_RD,    // read next sorted record
    S_EM_WAIT,  // load output register
    S_EM_HOLD   // wait for the sink to take the item
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;      // records in the current set
  logic              ovf_q;      // a record of the set was discarded
  logic [SWAP_W-1:0] swap_q;
  logic [CW-1:0]     bi_q;       // build counter, counts down to zero
  logic [CW-1:0]     hs_q;       // heap size during extraction
  logic [CW-1:0]     size_q;     // size of the heap being sifted
  logic [AW-1:0]     node_q;     // hole position of the sift
  logic              build_q;    // sift belongs to the build phase
  rec_t              cur_q;      // record being sifted down
  rec_t              lc_q;       // left child, or old root during extraction
  logic [AW-1:0]     k_q;        // emit index
  rec_t              out_rec_q;
  logic              out_valid_q;
  logic              out_last_q;

  // record memory port
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  rec_t          ram_wdata;
  logic [AW-1:0] ram_raddr;
  rec_t          ram_rdata;

  // input side
  rec_t          in_rec;
  logic          in_acc;
  logic          room;
  logic [CW-1:0] n_new;

  assign in_rec   = '{key: in_i.key, marks: in_i.marks, name_tag: in_i.name_tag};
  assign in_i.ready = (state_q == S_LOAD);
  assign in_acc   = in_i.valid && in_i.ready;
  assign room     = (cnt_q < CW'(MAX_RECORDS));
  assign n_new    = room ? (cnt_q + CW'(1)) : cnt_q;

  // sift-down child indices and the compare
  logic [XW-1:0] lc_x, rc_x, size_x;
  logic          lc_ok, rc_ok;
  logic          pick_l, pick_r, moved;
  rec_t          mid_rec, big_rec;
  logic [XW-1:0] big_idx;
  logic [CW-1:0] bi_m1, hs_m1;

  assign lc_x   = {1'b0, node_q, 1'b1};
  assign rc_x   = lc_x + XW'(1);
  assign size_x = XW'(size_q);
  assign lc_ok  = (lc_x < size_x);
  assign rc_ok  = (rc_x < size_x);
  assign bi_m1  = bi_q - CW'(1);
  assign hs_m1  = hs_q - CW'(1);

  // ties keep the parent, and the right child wins only on a strictly larger key
  assign pick_l  = (lc_q.key > cur_q.key);
  assign mid_rec = pick_l ? lc_q : cur_q;
  assign pick_r  = rc_ok && (ram_rdata.key > mid_rec.key);
  assign big_rec = pick_r ? ram_rdata : mid_rec;
  assign moved   = pick_l || pick_r;
  assign big_idx = pick_r ? rc_x : lc_x;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = node_q;
    ram_wdata = cur_q;
    ram_raddr = '0;
    case (state_q)
      S_LOAD: begin
        ram_we    = in_acc && room;
        ram_waddr = cnt_q[AW-1:0];
        ram_wdata = in_rec;
      end
      S_BUILD: begin
        ram_raddr = bi_m1[AW-1:0];
      end
      S_LEFT: begin
        ram_raddr = lc_x[AW-1:0];
        ram_we    = !lc_ok;   // sift ends, drop the record into the hole
      end
      S_RIGHT: begin
        ram_raddr = rc_x[AW-1:0];
      end
      S_CMP: begin
        ram_we    = 1'b1;
        ram_wdata = moved ? big_rec : cur_q;
      end
      S_EXT: begin
        ram_raddr = '0;
      end
      S_EXT_A: begin
        ram_raddr = hs_m1[AW-1:0];
      end
      S_EXT_B: begin
        ram_we    = 1'b1;
        ram_waddr = hs_m1[AW-1:0];
        ram_wdata = lc_q;
      end
      S_EM_RD: begin
        ram_raddr = k_q;
      end
      default: begin
        ram_raddr = '0;
      end
    endcase
  end

  hsc_ram #(
    .DEPTH (MAX_RECORDS),
    .WIDTH ($bits(rec_t))
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      swap_q      <= '0;
      bi_q        <= '0;
      hs_q        <= '0;
      size_q      <= '0;
      node_q      <= '0;
      build_q     <= 1'b0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            cnt_q <= n_new;
            if (!room) begin
              ovf_q <= 1'b1;
            end
            if (in_i.last) begin
              swap_q  <= '0;
              bi_q    <= n_new >> 1;
              build_q <= 1'b1;
              state_q <= S_BUILD;
            end
          end
        end
        S_BUILD: begin
          if (bi_q != '0) begin
            node_q  <= bi_m1[AW-1:0];
            size_q  <= cnt_q;
            bi_q    <= bi_m1;
            state_q <= S_TOP;
          end else begin
            hs_q    <= cnt_q;
            build_q <= 1'b0;
            state_q <= S_EXT;
          end
        end
        S_TOP: begin
          cur_q   <= ram_rdata;
          state_q <= S_LEFT;
        end
        S_LEFT: begin
          if (lc_ok) begin
            state_q <= S_RIGHT;
          end else begin
            state_q <= build_q ? S_BUILD : S_EXT;
          end
        end
        S_RIGHT: begin
          lc_q    <= ram_rdata;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (moved) begin
            node_q  <= big_idx[AW-1:0];
            if (swap_q != SWAP_MAX) begin
              swap_q <= swap_q + SWAP_W'(1);
            end
            state_q <= S_LEFT;
          end else begin
            state_q <= build_q ? S_BUILD : S_EXT;
          end
        end
        S_EXT: begin
          if (hs_q > CW'(1)) begin
            state_q <= S_EXT_A;
          end else begin
            k_q     <= '0;
            state_q <= S_EM_RD;
          end
        end
        S_EXT_A: begin
          lc_q    <= ram_rdata;
          state_q <= S_EXT_B;
        end
        S_EXT_B: begin
          cur_q   <= ram_rdata;
          if (swap_q != SWAP_MAX) begin
            swap_q <= swap_q + SWAP_W'(1);
          end
          hs_q    <= hs_m1;
          size_q  <= hs_m1;
          node_q  <= '0;
          state_q <= S_LEFT;
        end
        S_EM_RD: begin
          state_q <= S_EM_WAIT;
        end
        S_EM_WAIT: begin
          out_rec_q   <= ram_rdata;
          out_valid_q <= 1'b1;
          out_last_q  <= ((CW'(k_q) + CW'(1)) == cnt_q);
          state_q     <= S_EM_HOLD;
        end
        S_EM_HOLD: begin
          if (out_o.ready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              cnt_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + AW'(1);
              state_q <= S_EM_RD;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  // result item
  assign out_o.valid        = out_valid_q;
  assign out_o.key_res      = out_rec_q.key;
  assign out_o.marks_res    = out_rec_q.marks;
  assign out_o.name_tag_res = out_rec_q.name_tag;
  assign out_o.swap_count   = swap_q;
  assign out_o.dropped      = ovf_q;
  assign out_o.last_out     = out_last_q;

`ifndef ASSERT_OFF
  // loading and emitting never overlap
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_i.ready && out_o.valid))
    else $error("input ready while a result is pending");

  // the record count never passes the memory depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_RECORDS))
    else $error("record count beyond capacity");

  // sort writes stay inside the current set
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_LOAD) |-> (CW'(ram_waddr) < cnt_q))
    else $error("sort write outside the stored records");

  // the final result of a run leaves the block clear for the next set
  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.last_out) |=> (cnt_q == '0 && !ovf_q
      && state_q == S_LOAD))
    else $error("set state not cleared after the final result");
`endif

endmodule

`default_nettype wire

// ===== test/hsc_checker.sv =====
module hsc_checker import hsc_pkg::*; #(
  parameter int unsigned MAX_RECORDS = 64
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hsc_in_if           in_i,
  hsc_out_if          out_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    rec_t              rec;
    logic [SWAP_W-1:0] swap_count;
    logic              dropped;
    logic              last_out;
  } sorted_rec_t;

  rec_t              held_recs [MAX_RECORDS];
  int unsigned       held_count;
  logic              overflow_seen;
  logic [SWAP_W-1:0] swap_total;
  sorted_rec_t       sorted_q [$];
  int unsigned       fail_count = 0;

  assign fail_count_o = fail_count;

  task automatic swap_held(input int unsigned a, input int unsigned b);
    rec_t t;
    t            = held_recs[a];
    held_recs[a] = held_recs[b];
    held_recs[b] = t;
    if (swap_total != SWAP_MAX) swap_total++;
  endtask

  task automatic sift_held(input int unsigned heap_len, input int unsigned root);
    int unsigned node, big, lc, rc;
    node = root;
    forever begin
      big = node;
      lc  = 2 * node + 1;
      rc  = 2 * node + 2;
      if (lc < heap_len && held_recs[lc].key > held_recs[big].key) big = lc;
      if (rc < heap_len && held_recs[rc].key > held_recs[big].key) big = rc;
      if (big == node) break;
      swap_held(node, big);
      node = big;
    end
  endtask

  // build by sift-down, then move root to tail until one is left
  task automatic heap_sort_held();
    int unsigned i;
    swap_total = '0;
    for (i = held_count / 2; i > 0; i--) sift_held(held_count, i - 1);
    for (i = held_count; i > 1; i--) begin
      swap_held(0, i - 1);
      sift_held(i - 1, 0);
    end
  endtask

  task automatic take_record();
    rec_t        r;
    sorted_rec_t item;
    r.key      = in_i.key;
    r.marks    = in_i.marks;
    r.name_tag = in_i.name_tag;
    if (held_count < MAX_RECORDS) begin
      held_recs[held_count] = r;
      held_count++;
    end else begin
      overflow_seen = 1'b1;
    end
    if (in_i.last) begin
      heap_sort_held();
      for (int k = 0; k < held_count; k++) begin
        item.rec        = held_recs[k];
        item.swap_count = swap_total;
        item.dropped    = overflow_seen;
        item.last_out   = (k == held_count - 1);
        sorted_q.push_back(item);
      end
      held_count    = 0;
      overflow_seen = 1'b0;
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  task automatic check_result();
    sorted_rec_t want;
    if (sorted_q.size() == 0) begin
      $error("result with no record waiting: key_res %0h", out_i.key_res);
      fail_count++;
    end else begin
      want = sorted_q.pop_front();
      compare_field("key_res", 32'(want.rec.key), 32'(out_i.key_res));
      compare_field("marks_res", 32'(want.rec.marks), 32'(out_i.marks_res));
      compare_field("name_tag_res", 32'(want.rec.name_tag), 32'(out_i.name_tag_res));
      compare_field("swap_count", 32'(want.swap_count), 32'(out_i.swap_count));
      compare_field("dropped", 32'(want.dropped), 32'(out_i.dropped));
      compare_field("last_out", 32'(want.last_out), 32'(out_i.last_out));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_count    = 0;
      overflow_seen = 1'b0;
      swap_total    = '0;
      sorted_q.delete();
    end else begin
      if (out_i.valid && out_i.ready) check_result();
      if (in_i.valid && in_i.ready) take_record();
    end
    pending_o <= sorted_q.size();
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import hsc_pkg::*;

  localparam int unsigned CAPACITY     = 64;
  localparam int unsigned ITEM_TARGET  = 420;
  localparam int unsigned DRAIN_CYCLES = 100;

  // receiver behavior, picked per stretch of cycles
  typedef enum int unsigned {
    RX_OPEN,
    RX_COIN,
    RX_CHOKED,
    RX_PERIODIC
  } rx_mode_e;

  // how keys of one set are drawn
  typedef enum int unsigned {
    KEYS_ANY,
    KEYS_TIED,
    KEYS_RISING,
    KEYS_FALLING
  } key_mode_e;

  logic        clk_i;
  logic        rst_ni;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent;
  int unsigned sets_closed;
  int unsigned overfull_sets;
  int unsigned burst_left;

  hsc_in_if  in_if ();
  hsc_out_if out_if ();

  heap_sort_with_swap_count #(
    .MAX_RECORDS (CAPACITY)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // watches both channels, predicts the sorted output and compares
  hsc_checker #(
    .MAX_RECORDS (CAPACITY)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("heap_sort_with_swap_count: mismatch");
    $finish;
  end

  // receiver: a new stall pattern is drawn at random for each stretch
  initial begin
    rx_mode_e    rx_mode;
    int unsigned phase;
    out_if.ready = 1'b0;
    rx_mode      = RX_OPEN;
    phase        = 0;
    forever begin
      @(negedge clk_i);
      if (phase == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        phase   = $urandom_range(8, 80);
      end
      phase--;
      case (rx_mode)
        RX_OPEN:   out_if.ready <= 1'b1;
        RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
        RX_CHOKED: out_if.ready <= ($urandom_range(0, 7) == 0);
        default:   out_if.ready <= (phase % 4 != 0);
      endcase
    end
  end

  // drive one item at the falling edge, hold until taken, then maybe idle
  task automatic put_record(input logic [KEY_W-1:0] key, input logic [MARK_W-1:0] marks,
                            input logic [TAG_W-1:0] tag, input logic last);
    int unsigned gap;
    @(negedge clk_i);
    in_if.valid    <= 1'b1;
    in_if.key      <= key;
    in_if.marks    <= marks;
    in_if.name_tag <= tag;
    in_if.last     <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    if (last) sets_closed++;
    // bursts of random length, gaps of random length between them
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  endtask

  // lower valid and hold off until every sorted record is out
  task automatic drain_results();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    wait (pending == 0);
  endtask

  initial begin
    int unsigned      set_idx;
    int unsigned      set_len;
    int unsigned      pick;
    key_mode_e        key_mode;
    logic [KEY_W-1:0] base;
    logic [KEY_W-1:0] key;
    logic [31:0]      rand_word;

    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.key      = '0;
    in_if.marks    = '0;
    in_if.name_tag = '0;
    in_if.last     = 1'b0;
    items_sent     = 0;
    sets_closed    = 0;
    overfull_sets  = 0;
    burst_left     = 1;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // single-record sets: all ones, then all zeros, no exchange at all
    put_record('1, '1, '1, 1'b1);
    put_record('0, '0, '0, 1'b1);
    // two records, in order and reversed
    put_record(16'd1, 10'd1, 16'h0001, 1'b0);
    put_record(16'd2, 10'd2, 16'h0002, 1'b1);
    put_record(16'hffff, 10'h3ff, 16'h1111, 1'b0);
    put_record(16'h0000, 10'h000, 16'h2222, 1'b1);
    // all keys equal: order comes only from the heap exchanges
    for (int k = 0; k < 5; k++) put_record(16'd7, 10'(k), 16'(16'h0100 + k), k == 4);
    // mixed ties
    put_record(16'd3, 10'd10, 16'h0a00, 1'b0);
    put_record(16'd1, 10'd11, 16'h0a01, 1'b0);
    put_record(16'd3, 10'd12, 16'h0a02, 1'b0);
    put_record(16'd1, 10'd13, 16'h0a03, 1'b0);
    put_record(16'd2, 10'd14, 16'h0a04, 1'b0);
    put_record(16'd3, 10'd15, 16'h0a05, 1'b1);
    // alternating bit patterns on every field
    put_record(16'haaaa, 10'h2aa, 16'h5555, 1'b0);
    put_record(16'h5555, 10'h155, 16'haaaa, 1'b0);
    put_record(16'h8001, 10'h201, 16'h7ffe, 1'b1);

    // sender holds off until the directed sets are fully out
    drain_results();

    set_idx = 0;
    while (items_sent < ITEM_TARGET) begin
      // first a set whose closing record meets a full store, then an exactly full one
      if (set_idx == 0) begin
        set_len = CAPACITY + 1;
      end else if (set_idx == 1) begin
        set_len = CAPACITY;
      end else begin
        pick = $urandom_range(0, 19);
        if (pick == 0) set_len = CAPACITY + $urandom_range(1, 4);
        else if (pick == 1) set_len = CAPACITY;
        else set_len = $urandom_range(1, 12);
      end
      key_mode = key_mode_e'($urandom_range(0, 3));
      base     = KEY_W'($urandom);
      for (int k = 0; k < set_len; k++) begin
        case (key_mode)
          KEYS_ANY:     key = KEY_W'($urandom);
          KEYS_TIED:    key = base + KEY_W'($urandom_range(0, 2));
          KEYS_RISING:  key = base + KEY_W'(k);
          default:      key = base - KEY_W'(k);
        endcase
        rand_word = $urandom;
        put_record(key, rand_word[MARK_W-1:0], rand_word[31:32-TAG_W], k == set_len - 1);
      end
      if (set_len > CAPACITY) overfull_sets++;
      // a second full pause partway through
      if (set_idx == 8) drain_results();
      set_idx++;
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("sent %0d records in %0d sets, %0d sets ran past the store capacity",
             items_sent, sets_closed, overfull_sets);
    $display("ties, ordered, reversed and random keys, with sender gaps and receiver stalls");
    if (fail_count == 0) begin
      $display("heap_sort_with_swap_count: match");
    end else begin
      $display("heap_sort_with_swap_count: mismatch");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/hsc_pkg.sv
design/hsc_in_if.sv
design/hsc_out_if.sv
design/hsc_ram.sv
design/heap_sort_with_swap_count.sv
test/hsc_checker.sv
test/tb.sv
